// File: design/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/jsc_pkg.sv
`timescale 1ns / 1ps

package jsc_pkg;

	localparam logic [31:0] MAX_BYTES_RESET = 32'd20000000;

	localparam logic [1:0] REQ_NEXT  = 2'd0;
	localparam logic [1:0] REQ_FIRST = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;

	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] MK_SOI   = 8'hD8;
	localparam logic [7:0] MK_RST0  = 8'hD0;
	localparam logic [7:0] MK_RST7  = 8'hD7;
	localparam logic [7:0] MK_EOI   = 8'hD9;
	localparam logic [7:0] MK_SOS   = 8'hDA;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_MARK1 = 7'b0000010,
		PH_MARK2 = 7'b0000100,
		PH_LEN1  = 7'b0001000,
		PH_LEN2  = 7'b0010000,
		PH_BODY  = 7'b0100000,
		PH_SCAN  = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY       = 3'd0,
		ST_COMPLETE   = 3'd1,
		ST_LIMIT      = 3'd2,
		ST_BAD_HEADER = 3'd3,
		ST_NO_MARKER  = 3'd4,
		ST_BAD_LENGTH = 3'd5,
		ST_TOO_SMALL  = 3'd6,
		ST_SRC_END    = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       kept;
		logic       done_res;
		status_t    status;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  marker;
		logic [16:0] seg_len;
		logic [16:0] seg_pos;
		logic [31:0] count;
		logic        last_ff;
		logic        b4z;
	} carve_state_t;

	localparam carve_state_t CARVE_IDLE = '{
		phase: PH_IDLE, marker: 8'h00, seg_len: 17'd0, seg_pos: 17'd0,
		count: 32'd0, last_ff: 1'b0, b4z: 1'b0
	};

	localparam carve_state_t CARVE_START = '{
		phase: PH_MARK1, marker: 8'h00, seg_len: 17'd0, seg_pos: 17'd0,
		count: 32'd0, last_ff: 1'b0, b4z: 1'b0
	};

	function automatic logic is_standalone(input logic [7:0] code);
		return (code == MK_SOI) || ((code >= MK_RST0) && (code <= MK_RST7)) ||
			(code == MK_EOI) || (code == MK_SOS);
	endfunction

endpackage

// File: design/jsc_item_if.sv
`timescale 1ns / 1ps

interface jsc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
	modport monitor (input valid, input req_type, input data_byte, input ready);
endinterface

// File: design/jsc_result_if.sv
`timescale 1ns / 1ps

interface jsc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       kept;
	logic       done_res;
	logic [2:0] status;

	modport source (output valid, output out_byte, output kept, output done_res,
		output status, input ready);
	modport sink (input valid, input out_byte, input kept, input done_res,
		input status, output ready);
	modport monitor (input valid, input out_byte, input kept, input done_res,
		input status, input ready);
endinterface

// File: design/jsc_cfg_if.sv
`timescale 1ns / 1ps

interface jsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] max_bytes;

	modport source (output valid, output max_bytes, input ready);
	modport sink (input valid, input max_bytes, output ready);
	modport monitor (input valid, input max_bytes, input ready);
endinterface

// File: design/jsc_in_stage.sv
`timescale 1ns / 1ps

module jsc_in_stage import jsc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	jsc_item_if.sink item,
	input  logic   advance,
	output logic   valid_s1,
	output item_t  item_s1
);

	logic take;

	assign item.ready = !valid_s1 || advance;
	assign take = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{req_type: item.req_type, data_byte: item.data_byte};
		end
	end

endmodule

// File: design/jsc_parser.sv
`timescale 1ns / 1ps

module jsc_parser import jsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	jsc_cfg_if.sink cfg,
	input  item_t item_s1,
	input  logic  advance,
	output res_t  res
);

	carve_state_t st_q;
	carve_state_t nxt;
	logic [31:0]  max_q;
	logic [31:0]  cnt_inc;
	logic [15:0]  len16;
	logic [7:0]   b;
	logic         bnd;
	logic         fin;
	status_t      fin_status;

	assign cfg.ready = 1'b1;
	assign b = item_s1.data_byte;

	always_comb begin
		nxt = st_q;
		res = '0;
		res.status = ST_BUSY;
		bnd = 1'b0;
		fin = 1'b0;
		fin_status = ST_COMPLETE;
		cnt_inc = st_q.count;
		len16 = '0;
		unique case (item_s1.req_type)
			REQ_END: begin
				if (st_q.phase != PH_IDLE) begin
					nxt.phase = PH_IDLE;
					res.done_res = 1'b1;
					res.status = ST_SRC_END;
				end
			end
			REQ_NEXT, REQ_FIRST: begin
				res.out_byte = b;
				if (item_s1.req_type == REQ_FIRST) begin
					nxt = CARVE_START;
				end
				if (nxt.phase != PH_IDLE) begin
					if (nxt.count == 32'd4) begin
						nxt.b4z = (b == 8'h00);
					end
					if ((nxt.count == 32'd5) && nxt.b4z && (b == 8'h00)) begin
						nxt.phase = PH_IDLE;
						res.done_res = 1'b1;
						res.status = ST_BAD_HEADER;
					end else begin
						cnt_inc = (&nxt.count) ? nxt.count : nxt.count + 32'd1;
						nxt.count = cnt_inc;
						res.kept = 1'b1;
						unique case (nxt.phase)
							PH_MARK1: begin
								if (b != BYTE_FF) begin
									nxt.phase = PH_IDLE;
									res.kept = 1'b0;
									res.done_res = 1'b1;
									res.status = ST_NO_MARKER;
								end else begin
									nxt.phase = PH_MARK2;
								end
							end
							PH_MARK2: begin
								nxt.marker = b;
								if (is_standalone(b)) begin
									if (b == MK_SOS) begin
										nxt.phase = PH_SCAN;
										nxt.last_ff = 1'b0;
									end else begin
										bnd = 1'b1;
									end
								end else begin
									nxt.phase = PH_LEN1;
								end
							end
							PH_LEN1: begin
								nxt.seg_len = {1'b0, b, 8'h00};
								nxt.phase = PH_LEN2;
							end
							PH_LEN2: begin
								len16 = {nxt.seg_len[15:8], b};
								if (len16 < 16'd2) begin
									nxt.phase = PH_IDLE;
									res.kept = 1'b0;
									res.done_res = 1'b1;
									res.status = ST_BAD_LENGTH;
								end else begin
									nxt.seg_len = {1'b0, len16} + 17'd2;
									nxt.seg_pos = 17'd4;
									if (nxt.seg_pos >= nxt.seg_len) begin
										bnd = 1'b1;
									end else begin
										nxt.phase = PH_BODY;
									end
								end
							end
							PH_BODY: begin
								nxt.seg_pos = nxt.seg_pos + 17'd1;
								if (nxt.seg_pos >= nxt.seg_len) begin
									bnd = 1'b1;
								end
							end
							PH_SCAN: begin
								if (nxt.last_ff && (b == MK_EOI)) begin
									nxt.marker = MK_EOI;
									fin = 1'b1;
									fin_status = ST_COMPLETE;
								end else begin
									nxt.last_ff = (b == BYTE_FF);
								end
							end
							default: begin
								nxt.phase = PH_IDLE;
								res.kept = 1'b0;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase

		if (bnd) begin
			if (nxt.marker == MK_EOI) begin
				fin = 1'b1;
				fin_status = ST_COMPLETE;
			end else if (cnt_inc >= max_q) begin
				fin = 1'b1;
				fin_status = ST_LIMIT;
			end else begin
				nxt.phase = PH_MARK1;
			end
		end

		if (fin) begin
			nxt.phase = PH_IDLE;
			res.done_res = 1'b1;
			if (cnt_inc > 32'd2) begin
				res.status = fin_status;
				res.kept = 1'b1;
			end else begin
				res.status = ST_TOO_SMALL;
				res.kept = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= CARVE_IDLE;
			max_q <= MAX_BYTES_RESET;
		end else begin
			if (advance) begin
				st_q <= nxt;
			end
			if (cfg.valid) begin
				max_q <= cfg.max_bytes;
			end
		end
	end

endmodule

// File: design/jsc_out_stage.sv
`timescale 1ns / 1ps

module jsc_out_stage import jsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  res_t res,
	jsc_result_if.source result,
	output logic advance
);

	logic valid_s2;
	res_t res_s2;

	assign advance = valid_s1 && (!valid_s2 || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result.valid    = valid_s2;
	assign result.out_byte = res_s2.out_byte;
	assign result.kept     = res_s2.kept;
	assign result.done_res = res_s2.done_res;
	assign result.status   = res_s2.status;

endmodule

// File: design/jpeg_segment_carver_core.sv
`timescale 1ns / 1ps
// JPEG marker-segment carver. The item channel carries one byte per transaction
// with a request type: next byte, first byte of a new candidate, or source ended.
// Every item transaction yields exactly one result transaction, in order, which
// echoes the byte with a keep flag and, on the item that ends a carve, a final
// status. The configuration channel writes max_bytes; it is always ready, and the
// user must write it only while no item is in flight; the block does not enforce it.
// An accepted item is registered in the input stage, parsed into the result
// register when it advances, and offered on the result channel from that register.
// Throughput is one item per cycle while the result receiver keeps up; the
// combinational parse of the state machine and the 32-bit byte count compare
// against max_bytes set the clock.
// Reset clears both stages, puts the parser in the idle phase with all counters
// at zero, and loads max_bytes with 20000000.
// When the result receiver stalls, the result register holds its transaction,
// the input stage fills with one more item, and then item ready drops until the
// result is taken.

module jpeg_segment_carver_core import jsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	jsc_item_if.sink item,
	jsc_result_if.source result,
	jsc_cfg_if.sink cfg
);

	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	res_t  res;

	jsc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	jsc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.advance (advance),
		.res     (res)
	);

	jsc_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.result   (result),
		.advance  (advance)
	);

endmodule

// File: design/jsc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsc_checker import jsc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_byte,
	input logic       kept,
	input logic       done_res,
	input logic [2:0] status
);

	`ASSERT_IMPLY(a_done_has_status, clk, arst_n, valid, done_res == (status != ST_BUSY), "final flag and status disagree")

	`ASSERT_IMPLY(a_reject_not_kept, clk, arst_n, valid && (status >= ST_BAD_HEADER), !kept, "rejecting transaction kept")

	`ASSERT_IMPLY(a_success_kept, clk, arst_n, valid && ((status == ST_COMPLETE) || (status == ST_LIMIT)), kept, "successful end not kept")

	`ASSERT_NEXT(a_stall_holds, clk, arst_n, valid && !ready, valid && $stable({out_byte, kept, done_res, status}), "stalled result changed")

endmodule

bind jpeg_segment_carver_core jsc_checker u_jsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (result.valid),
	.ready    (result.ready),
	.out_byte (result.out_byte),
	.kept     (result.kept),
	.done_res (result.done_res),
	.status   (result.status)
);
